FILE: src/fcwp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcwp_pkg;

   localparam int TABLE_DEPTH_DEF = 4096;
   localparam int CHANNELS_DEF    = 4;
   localparam int MAX_CHANNELS    = 4;

   localparam int LEN_W    = 13;
   localparam int CODE_W   = 12;
   localparam int ADDR_W   = 12;
   localparam int WORD_W   = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [WORD_W-1:0] WORD_A = 16'h1000;
   localparam logic [WORD_W-1:0] WORD_B = 16'hD000;

   typedef enum logic [1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_TICK = 2'd1,
      FUNC_STOP = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_CH0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_CH1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_CH2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_CH3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_CH0   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_CH1   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_CH2   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_CH3   = 3'd7;

   // Build a DAC command word: A channels on even slots, B channels on odd ones.
   function automatic logic [WORD_W-1:0] make_word(input logic odd,
                                                  input logic [CODE_W-1:0] code);
      logic [WORD_W-1:0] base;
      base = odd ? WORD_B : WORD_A;
      return base | {{(WORD_W-CODE_W){1'b0}}, code};
   endfunction

endpackage

`default_nettype wire

FILE: src/four_channel_wave_player_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake              | Payload
// req     | in        | req_tvalid/req_tready  | tuser: func; tdata: channel, address,
//         |           |                        |   sample_value, trigger_level
// rsp     | out       | rsp_tvalid/rsp_tready  | tdata: word_ch0..word_ch3
// csr     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// One item per cycle while req_tready is high. A tick or stop is registered at
// accept, a tick with its wave table read; the command words are then formed
// into the output register as the stage advances. Loads write the per-channel
// table memory at accept and give no result. Reset clears phases, lengths (to 1),
// idle levels and valids; table contents are undefined until written. A stalled
// rsp side holds the pipeline; req_tready drops only when both stages are full.
module four_channel_wave_player_core #(
   parameter int TABLE_DEPTH = fcwp_pkg::TABLE_DEPTH_DEF,
   parameter int CHANNELS    = fcwp_pkg::CHANNELS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // [1:0] func
   // [1:0] channel, [13:2] address, [25:14] sample_value, [26] trigger_level
   input  wire logic [31:0] req_tdata,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] word_ch0, [31:16] word_ch1, [47:32] word_ch2, [63:48] word_ch3
   output logic [63:0]      rsp_tdata,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [fcwp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fcwp_pkg::LEN_W-1:0]     csr_data
);

   localparam int PW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
   localparam int LW = (PW + 1 > fcwp_pkg::LEN_W) ? PW + 1 : fcwp_pkg::LEN_W;
   localparam logic [LW-1:0] DEPTH_LW = LW'(TABLE_DEPTH);
   localparam int CW = fcwp_pkg::CODE_W;
   localparam int WW = fcwp_pkg::WORD_W;

   // request fields
   logic [1:0]    func;
   logic [1:0]    channel;
   logic [fcwp_pkg::ADDR_W-1:0] address;
   logic [CW-1:0] sample_value;
   logic          trigger_level;

   assign func          = req_tuser;
   assign channel       = req_tdata[1:0];
   assign address       = req_tdata[13:2];
   assign sample_value  = req_tdata[25:14];
   assign trigger_level = req_tdata[26];

   // configuration
   logic [fcwp_pkg::LEN_W-1:0] len_ff  [fcwp_pkg::MAX_CHANNELS];
   logic [CW-1:0]              idle_ff [fcwp_pkg::MAX_CHANNELS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fcwp_pkg::MAX_CHANNELS; i++) begin
            len_ff[i]  <= fcwp_pkg::LEN_W'(1);
            idle_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            fcwp_pkg::CSR_LENGTH_CH0: len_ff[0]  <= csr_data;
            fcwp_pkg::CSR_LENGTH_CH1: len_ff[1]  <= csr_data;
            fcwp_pkg::CSR_LENGTH_CH2: len_ff[2]  <= csr_data;
            fcwp_pkg::CSR_LENGTH_CH3: len_ff[3]  <= csr_data;
            fcwp_pkg::CSR_IDLE_CH0:   idle_ff[0] <= csr_data[CW-1:0];
            fcwp_pkg::CSR_IDLE_CH1:   idle_ff[1] <= csr_data[CW-1:0];
            fcwp_pkg::CSR_IDLE_CH2:   idle_ff[2] <= csr_data[CW-1:0];
            fcwp_pkg::CSR_IDLE_CH3:   idle_ff[3] <= csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic s1_idle_ff;
   logic out_valid_ff;
   logic advance;
   logic accept;
   logic is_tick, is_stop, is_load;
   logic rd_en;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign is_load    = (func == fcwp_pkg::FUNC_LOAD);
   assign is_tick    = (func == fcwp_pkg::FUNC_TICK);
   assign is_stop    = (func == fcwp_pkg::FUNC_STOP);
   assign rd_en      = accept && is_tick;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance)
         s1_valid_in = 1'b0;
      if (accept && (is_tick || is_stop))
         s1_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance)
            out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (is_tick || is_stop))
         s1_idle_ff <= is_stop || trigger_level;
   end

   // load address check
   logic [LW-1:0] addr_lw;
   logic          addr_ok;
   logic          chan_ok;
   logic          load_en;

   assign addr_lw = LW'(address);
   assign addr_ok = addr_lw < DEPTH_LW;
   assign chan_ok = {1'b0, channel} < 3'(CHANNELS);
   assign load_en = accept && is_load && addr_ok && chan_ok;

   logic [WW-1:0] word_in [fcwp_pkg::MAX_CHANNELS];
   logic [WW-1:0] word_ff [fcwp_pkg::MAX_CHANNELS];

   for (genvar c = 0; c < fcwp_pkg::MAX_CHANNELS; c++) begin : g_ch
      if (c < CHANNELS) begin : g_on
         logic [CW-1:0] mem [TABLE_DEPTH];
         logic [CW-1:0] rd_ff;
         logic [PW-1:0] phase_ff;
         logic [LW-1:0] len_lw;
         logic [LW-1:0] eff_len;
         logic [LW-1:0] phase_nxt;
         logic [CW-1:0] code;

         always_ff @(posedge clock) begin
            if (load_en && channel == 2'(c))
               mem[addr_lw[PW-1:0]] <= sample_value;
         end

         always_ff @(posedge clock) begin
            if (rd_en)
               rd_ff <= mem[phase_ff];
         end

         assign len_lw    = LW'(len_ff[c]);
         assign phase_nxt = LW'(phase_ff) + LW'(1);

         always_comb begin
            eff_len = len_lw;
            if (len_lw == '0)
               eff_len = LW'(1);
            else if (len_lw > DEPTH_LW)
               eff_len = DEPTH_LW;
         end

         // advance on tick, wrap at the channel length, clear on stop
         always_ff @(posedge clock) begin
            if (reset) begin
               phase_ff <= '0;
            end else if (accept && is_stop) begin
               phase_ff <= '0;
            end else if (accept && is_tick) begin
               if (phase_nxt >= eff_len)
                  phase_ff <= '0;
               else
                  phase_ff <= phase_nxt[PW-1:0];
            end
         end

         assign code       = s1_idle_ff ? idle_ff[c] : rd_ff;
         assign word_in[c] = fcwp_pkg::make_word(c % 2 == 1, code);
      end else begin : g_off
         assign word_in[c] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         for (int i = 0; i < fcwp_pkg::MAX_CHANNELS; i++)
            word_ff[i] <= word_in[i];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {word_ff[3], word_ff[2], word_ff[1], word_ff[0]};

endmodule

`default_nettype wire

FILE: tb/tb_four_channel_wave_player_core.sv
`timescale 1ns / 1ps

module tb_four_channel_wave_player_core;

   localparam int DEPTH      = fcwp_pkg::TABLE_DEPTH_DEF;
   localparam int NCH        = fcwp_pkg::CHANNELS_DEF;
   localparam int STALL_MAX  = 2000;
   localparam int LONG_HOLD  = 300;
   localparam int PHASE_SIZE = 170;

   typedef struct packed {
      fcwp_pkg::func_type func;
      logic [1:0]  chan;
      logic [11:0] addr;
      logic [11:0] code;
      logic        trig;
      logic        has_rsp;
      logic [63:0] words;
   } dac_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [fcwp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [fcwp_pkg::LEN_W-1:0]     csr_data = '0;

   // shadow of the player state
   logic [11:0]  wave_mem [NCH][DEPTH];
   bit           wave_set [NCH][DEPTH];
   int unsigned  play_pos [4];
   logic [12:0]  len_reg [4];
   logic [11:0]  idle_reg [4];

   dac_item_type pending_items[$];
   logic [63:0]  words_due[$];
   dac_item_type cur_req;
   bit           req_fire = 1'b0;
   int           req_gap = 0;
   int           rsp_gap = 0;
   int           idle_odds = 4;
   bit           hold_go = 1'b0;
   bit           hold_done = 1'b0;
   int           hold_cnt = 0;
   int           stall_cycles = 0;
   int           mismatches = 0;
   int           item_count = 0;

   four_channel_wave_player_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] cmd_word(int ch, logic [11:0] code);
      return ((ch % 2) ? 16'hD000 : 16'h1000) | {4'h0, code};
   endfunction

   function automatic int unsigned play_len(int ch);
      int unsigned n;
      n = 32'(len_reg[ch]);
      if (n == 0) n = 1;
      if (n > DEPTH) n = DEPTH;
      return n;
   endfunction

   // Advance the shadow state by one item and fill in the words it should produce.
   function automatic dac_item_type dac_step(dac_item_type it);
      logic [11:0] code;
      it.has_rsp = 1'b0;
      it.words   = '0;
      case (it.func)
         fcwp_pkg::FUNC_LOAD: begin
            if (it.chan < NCH && it.addr < DEPTH) begin
               wave_mem[it.chan][it.addr] = it.code;
               wave_set[it.chan][it.addr] = 1'b1;
            end
         end
         fcwp_pkg::FUNC_TICK: begin
            it.has_rsp = 1'b1;
            for (int ch = 0; ch < NCH; ch++) begin
               code = it.trig ? idle_reg[ch] : wave_mem[ch][play_pos[ch] % DEPTH];
               it.words[16*ch +: 16] = cmd_word(ch, code);
               if (play_pos[ch] + 1 >= play_len(ch))
                  play_pos[ch] = 0;
               else
                  play_pos[ch] = play_pos[ch] + 1;
            end
         end
         fcwp_pkg::FUNC_STOP: begin
            it.has_rsp = 1'b1;
            for (int ch = 0; ch < NCH; ch++) begin
               it.words[16*ch +: 16] = cmd_word(ch, idle_reg[ch]);
               play_pos[ch] = 0;
            end
         end
         default: ;
      endcase
      return it;
   endfunction

   task automatic push_item(fcwp_pkg::func_type f, logic [1:0] c, logic [11:0] a,
                            logic [11:0] v, logic t);
      dac_item_type it;
      it      = '0;
      it.func = f;
      it.chan = c;
      it.addr = a;
      it.code = v;
      it.trig = t;
      it = dac_step(it);
      pending_items.push_back(it);
      item_count++;
   endtask

   // Load any table point that an ungated tick would read before it was written.
   task automatic push_tick(logic t);
      for (int ch = 0; ch < NCH; ch++) begin
         if (!t && !wave_set[ch][play_pos[ch]])
            push_item(fcwp_pkg::FUNC_LOAD, ch[1:0], play_pos[ch][11:0], 12'($urandom),
                      1'($urandom_range(0, 1)));
      end
      push_item(fcwp_pkg::FUNC_TICK, 2'($urandom), 12'($urandom), 12'($urandom), t);
   endtask

   task automatic csr_put(logic [fcwp_pkg::CSR_IDX_W-1:0] idx,
                          logic [fcwp_pkg::LEN_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx < fcwp_pkg::CSR_IDLE_CH0)
         len_reg[idx] = val;
      else
         idle_reg[idx - fcwp_pkg::CSR_IDLE_CH0] = val[11:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_tvalid || words_due.size() != 0)
         @(posedge clock);
      // loads give no result; let the pipeline settle
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [fcwp_pkg::LEN_W-1:0] pick_len();
      case ($urandom_range(0, 9))
         0: return 13'd0;
         1: return 13'd1;
         2: return 13'd4096;
         3: return 13'h1FFF;
         4: return 13'd4095;
         5: return fcwp_pkg::LEN_W'($urandom_range(1, 8191));
         default: return fcwp_pkg::LEN_W'($urandom_range(1, 24));
      endcase
   endfunction

   function automatic logic [fcwp_pkg::LEN_W-1:0] pick_idle();
      case ($urandom_range(0, 4))
         0: return 13'd0;
         1: return 13'h0FFF;
         2: return 13'h1FFF;
         default: return fcwp_pkg::LEN_W'($urandom);
      endcase
   endfunction

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fire)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            req_gap = $urandom_range(0, 4);
            req_tvalid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            cur_req = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= cur_req.func;
            req_tdata  <= {5'b0, cur_req.trig, cur_req.code, cur_req.addr, cur_req.chan};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response sink
   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_cnt++;
         if (hold_cnt >= LONG_HOLD) hold_done = 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         rsp_gap = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin : mon
      logic [63:0] want;
      bit          rsp_fire;
      req_fire = !reset && req_tvalid && req_tready;
      rsp_fire = !reset && rsp_tvalid && rsp_tready;
      if (req_fire && cur_req.has_rsp)
         words_due.push_back(cur_req.words);
      if (rsp_fire) begin
         if (words_due.size() == 0) begin
            $error("unexpected result item %h", rsp_tdata);
            mismatches++;
         end else begin
            want = words_due.pop_front();
            for (int ch = 0; ch < 4; ch++) begin
               if (rsp_tdata[16*ch +: 16] !== want[16*ch +: 16]) begin
                  $error("word_ch%0d expected %h actual %h", ch, want[16*ch +: 16],
                         rsp_tdata[16*ch +: 16]);
                  mismatches++;
               end
            end
         end
      end
      if (req_fire || rsp_fire || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stim
      int r;
      int phase_start;
      for (int ch = 0; ch < 4; ch++) begin
         play_pos[ch] = 0;
         len_reg[ch]  = 13'd1;
         idle_reg[ch] = 12'd0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_put(fcwp_pkg::CSR_LENGTH_CH0, 13'd1);
      csr_put(fcwp_pkg::CSR_LENGTH_CH1, 13'd2);
      csr_put(fcwp_pkg::CSR_LENGTH_CH2, 13'd4096);
      csr_put(fcwp_pkg::CSR_LENGTH_CH3, 13'd0);
      csr_put(fcwp_pkg::CSR_IDLE_CH0, 13'h0000);
      csr_put(fcwp_pkg::CSR_IDLE_CH1, 13'h0FFF);
      csr_put(fcwp_pkg::CSR_IDLE_CH2, 13'h0AAA);
      csr_put(fcwp_pkg::CSR_IDLE_CH3, 13'h1555);

      // directed: extremes, all functions, gated and ungated ticks, wrap
      push_item(fcwp_pkg::FUNC_STOP, 2'b00, 12'h000, 12'h000, 1'b0);
      push_item(fcwp_pkg::FUNC_LOAD, 2'd0, 12'h000, 12'h000, 1'b0);
      push_item(fcwp_pkg::FUNC_LOAD, 2'd1, 12'h000, 12'hFFF, 1'b1);
      push_item(fcwp_pkg::FUNC_LOAD, 2'd1, 12'h001, 12'h555, 1'b0);
      push_item(fcwp_pkg::FUNC_LOAD, 2'd2, 12'h000, 12'hAAA, 1'b0);
      push_item(fcwp_pkg::FUNC_LOAD, 2'd2, 12'hFFF, 12'hFFF, 1'b0);
      push_item(fcwp_pkg::FUNC_LOAD, 2'd3, 12'h000, 12'h123, 1'b1);
      push_item(fcwp_pkg::FUNC_LOAD, 2'd0, 12'hFFF, 12'h800, 1'b0);
      push_tick(1'b0);
      push_tick(1'b0);
      push_tick(1'b1);
      push_item(fcwp_pkg::FUNC_NONE, 2'b11, 12'hFFF, 12'hFFF, 1'b1);
      push_item(fcwp_pkg::FUNC_NONE, 2'b00, 12'h000, 12'h000, 1'b0);
      push_tick(1'b0);
      push_item(fcwp_pkg::FUNC_STOP, 2'b11, 12'hFFF, 12'hFFF, 1'b1);
      push_tick(1'b0);
      push_tick(1'b1);

      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         case (ph)
            1: begin
               for (int i = 0; i < 4; i++)
                  csr_put(fcwp_pkg::CSR_IDX_W'(fcwp_pkg::CSR_LENGTH_CH0 + i), 13'h1FFF);
               for (int i = 0; i < 4; i++)
                  csr_put(fcwp_pkg::CSR_IDX_W'(fcwp_pkg::CSR_IDLE_CH0 + i), 13'h1FFF);
            end
            2: begin
               for (int i = 0; i < 4; i++)
                  csr_put(fcwp_pkg::CSR_IDX_W'(fcwp_pkg::CSR_LENGTH_CH0 + i), 13'd4096);
               for (int i = 0; i < 4; i++)
                  csr_put(fcwp_pkg::CSR_IDX_W'(fcwp_pkg::CSR_IDLE_CH0 + i), 13'h0FFF);
            end
            3: begin
               for (int i = 0; i < 4; i++)
                  csr_put(fcwp_pkg::CSR_IDX_W'(fcwp_pkg::CSR_LENGTH_CH0 + i), 13'd1);
               for (int i = 0; i < 4; i++)
                  csr_put(fcwp_pkg::CSR_IDX_W'(fcwp_pkg::CSR_IDLE_CH0 + i), 13'h0000);
            end
            default: begin
               for (int i = 0; i < 4; i++)
                  csr_put(fcwp_pkg::CSR_IDX_W'(fcwp_pkg::CSR_LENGTH_CH0 + i), pick_len());
               for (int i = 0; i < 4; i++)
                  csr_put(fcwp_pkg::CSR_IDX_W'(fcwp_pkg::CSR_IDLE_CH0 + i), pick_idle());
            end
         endcase
         idle_odds = (ph == 7) ? 0 : ((ph % 3 == 0) ? 3 : 8);
         // stall the sink for a long stretch while the source keeps offering
         if (ph == 1) hold_go = 1'b1;
         phase_start = item_count;
         while (item_count - phase_start < PHASE_SIZE) begin
            r = $urandom_range(0, 99);
            if (r < 38)
               push_item(fcwp_pkg::FUNC_LOAD, 2'($urandom),
                         ($urandom_range(0, 9) == 0) ? 12'($urandom)
                         : 12'($urandom_range(0, 31)), 12'($urandom),
                         1'($urandom_range(0, 1)));
            else if (r < 88)
               push_tick($urandom_range(0, 3) == 0);
            else if (r < 95)
               push_item(fcwp_pkg::FUNC_STOP, 2'($urandom), 12'($urandom), 12'($urandom),
                         1'($urandom_range(0, 1)));
            else
               push_item(fcwp_pkg::FUNC_NONE, 2'($urandom), 12'($urandom), 12'($urandom),
                         1'($urandom_range(0, 1)));
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
